[src/otgs_pkg.sv]
// Package with the shared types, constants and font functions of the OLED text glyph streamer.
package otgs_pkg;

    // Byte positions within the nine-byte sequence for one character.
    localparam logic [3:0] STEP_PAGE     = 4'd0;
    localparam logic [3:0] STEP_COL_LO   = 4'd1;
    localparam logic [3:0] STEP_COL_HI   = 4'd2;
    localparam logic [3:0] STEP_GLYPH0   = 4'd3;
    localparam logic [3:0] STEP_GLYPH4   = 4'd7;
    localparam logic [3:0] STEP_BLANK    = 4'd8;

    // Command prefixes of the display controller.
    localparam logic [7:0] CMD_PAGE_BASE   = 8'hB0;
    localparam logic [7:0] CMD_COL_LO_BASE = 8'h00;
    localparam logic [7:0] CMD_COL_HI_BASE = 8'h10;
    localparam logic [7:0] BLANK_COLUMN    = 8'h00;

    localparam logic [7:0] GLYPH_ADVANCE = 8'd6;

    // Glyph codes: 0 is blank, 1..10 are the digits, 11..23 the letters.
    typedef logic [4:0] t_glyph;

    localparam t_glyph GLYPH_BLANK = 5'd0;

    // One classified character handed from the front end to the back end.
    typedef struct packed {
        logic [2:0] page;
        logic [6:0] column;
        t_glyph     glyph;
    } t_slot;

    function automatic t_glyph glyph_index(input logic [7:0] code);
        t_glyph idx;
        idx = GLYPH_BLANK;
        if (code >= 8'h30 && code <= 8'h39) begin
            idx = 5'(code - 8'h30) + 5'd1;
        end else begin
            case (code)
                8'h52:   idx = 5'd11; // R
                8'h50:   idx = 5'd12; // P
                8'h61:   idx = 5'd13; // a
                8'h62:   idx = 5'd14; // b
                8'h65:   idx = 5'd15; // e
                8'h68:   idx = 5'd16; // h
                8'h69:   idx = 5'd17; // i
                8'h6C:   idx = 5'd18; // l
                8'h6F:   idx = 5'd19; // o
                8'h70:   idx = 5'd20; // p
                8'h72:   idx = 5'd21; // r
                8'h73:   idx = 5'd22; // s
                8'h79:   idx = 5'd23; // y
                default: idx = GLYPH_BLANK;
            endcase
        end
        return idx;
    endfunction

    // Five columns of a glyph, column 0 in the top byte, bit 0 = top row.
    function automatic logic [39:0] glyph_row(input t_glyph idx);
        logic [39:0] row;
        unique case (idx)
            5'd1:    row = 40'h3E_51_49_45_3E;
            5'd2:    row = 40'h00_42_7F_40_00;
            5'd3:    row = 40'h42_61_51_49_46;
            5'd4:    row = 40'h21_41_45_4B_31;
            5'd5:    row = 40'h18_14_12_7F_10;
            5'd6:    row = 40'h27_45_45_45_39;
            5'd7:    row = 40'h3C_4A_49_49_30;
            5'd8:    row = 40'h01_71_09_05_03;
            5'd9:    row = 40'h36_49_49_49_36;
            5'd10:   row = 40'h06_49_49_29_1E;
            5'd11:   row = 40'h7F_09_19_29_46;
            5'd12:   row = 40'h7F_09_09_09_06;
            5'd13:   row = 40'h20_54_54_54_78;
            5'd14:   row = 40'h7F_48_44_44_38;
            5'd15:   row = 40'h38_54_54_54_18;
            5'd16:   row = 40'h7F_08_04_04_78;
            5'd17:   row = 40'h00_44_7D_40_00;
            5'd18:   row = 40'h00_41_7F_40_00;
            5'd19:   row = 40'h38_44_44_44_38;
            5'd20:   row = 40'h7C_14_14_14_08;
            5'd21:   row = 40'h7C_08_04_04_08;
            5'd22:   row = 40'h48_54_54_54_24;
            5'd23:   row = 40'h0C_50_50_50_3C;
            default: row = 40'h0;
        endcase
        return row;
    endfunction

    function automatic logic [7:0] glyph_byte(input t_glyph idx, input logic [2:0] k);
        logic [39:0] row;
        logic [7:0]  b;
        row = glyph_row(idx);
        unique case (k)
            3'd0:    b = row[39:32];
            3'd1:    b = row[31:24];
            3'd2:    b = row[23:16];
            3'd3:    b = row[15:8];
            3'd4:    b = row[7:0];
            default: b = BLANK_COLUMN;
        endcase
        return b;
    endfunction

endpackage

[src/otgs_char_if.sv]
// Handshake interface that carries one text character word.
interface otgs_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       begins_text;
    logic [6:0] start_column;
    logic [2:0] start_page;

    modport source (output valid, output char_code, output begins_text,
                    output start_column, output start_page, input ready);
    modport sink   (input valid, input char_code, input begins_text,
                    input start_column, input start_page, output ready);
endinterface

[src/otgs_byte_if.sv]
// Handshake interface that carries one display byte word.
interface otgs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       is_command;
    logic       starts_transfer;
    logic       last;

    modport source (output valid, output byte_value, output is_command,
                    output starts_transfer, output last, input ready);
    modport sink   (input valid, input byte_value, input is_command,
                    input starts_transfer, input last, output ready);
endinterface

[src/otgs_front.sv]
// Front end: accepts characters, tracks the cursor and classifies the glyph.
module otgs_front
    import otgs_pkg::*;
#(
    parameter int DISPLAY_WIDTH = 128,
    parameter int PAGE_COUNT    = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    otgs_char_if.sink    i_char,
    input  logic         i_full,
    output logic         o_push,
    output t_slot        o_slot
);

    localparam logic [7:0] WIDTH_LIM = 8'(DISPLAY_WIDTH);
    localparam logic [3:0] PAGE_LIM  = 4'(PAGE_COUNT);

    logic [6:0] r_col, n_col;
    logic [3:0] r_page, n_page;

    logic [6:0] col0, col1;
    logic [3:0] pg0, pg1;
    logic [7:0] col2;
    logic       full0, pre_wrap, post_wrap, emit, accept;

    assign i_char.ready = !i_full;
    assign accept       = i_char.valid && !i_full;

    always_comb begin
        col0      = i_char.begins_text ? i_char.start_column : r_col;
        pg0       = i_char.begins_text ? {1'b0, i_char.start_page} : r_page;
        full0     = pg0 >= PAGE_LIM;
        pre_wrap  = ({1'b0, col0} + GLYPH_ADVANCE) > WIDTH_LIM;
        col1      = pre_wrap ? 7'd0 : col0;
        pg1       = pre_wrap ? pg0 + 4'd1 : pg0;
        emit      = !full0 && (pg1 < PAGE_LIM);
        col2      = {1'b0, col1} + GLYPH_ADVANCE;
        post_wrap = (col2 + GLYPH_ADVANCE) > WIDTH_LIM;

        if (!emit) begin
            n_col  = full0 ? col0 : col1;
            n_page = full0 ? pg0 : pg1;
        end else if (post_wrap) begin
            n_col  = 7'd0;
            n_page = pg1 + 4'd1;
        end else begin
            n_col  = col2[6:0];
            n_page = pg1;
        end
    end

    assign o_push        = accept && emit;
    assign o_slot.page   = pg1[2:0];
    assign o_slot.column = col1;
    assign o_slot.glyph  = glyph_index(i_char.char_code);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= 7'd0;
            r_page <= 4'd0;
        end else if (accept) begin
            r_col  <= n_col;
            r_page <= n_page;
        end
    end

endmodule

[src/otgs_queue.sv]
// Two-entry queue between the front end and the back end.
module otgs_queue
    import otgs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_slot i_slot,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_avail,
    output t_slot o_slot
);

    t_slot      r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_avail = r_count != 2'd0;
    assign o_slot  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[src/otgs_back.sv]
// Back end: turns one queued character into nine registered display bytes.
module otgs_back
    import otgs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_avail,
    input  t_slot       i_slot,
    output logic        o_pop,
    otgs_byte_if.source o_byte
);

    logic       r_busy;
    logic [3:0] r_step;
    t_slot      r_slot;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_cmd, r_start, r_last;

    logic       adv, emit_now;
    logic [3:0] step;
    t_slot      slot;
    logic [7:0] n_byte;
    logic       n_cmd, n_start, n_last;
    logic [2:0] k;

    // The output register may take a new word when empty or being drained.
    assign adv      = !r_valid || o_byte.ready;
    assign o_pop    = adv && !r_busy && i_avail;
    assign emit_now = adv && (r_busy || i_avail);
    assign step     = r_busy ? r_step : STEP_PAGE;
    assign slot     = r_busy ? r_slot : i_slot;

    always_comb begin
        k       = 3'(step - STEP_GLYPH0);
        n_byte  = BLANK_COLUMN;
        n_cmd   = 1'b0;
        n_start = 1'b1;
        n_last  = 1'b0;
        unique case (step)
            STEP_PAGE: begin
                n_byte = CMD_PAGE_BASE | {5'd0, slot.page};
                n_cmd  = 1'b1;
            end
            STEP_COL_LO: begin
                n_byte = CMD_COL_LO_BASE | {4'd0, slot.column[3:0]};
                n_cmd  = 1'b1;
            end
            STEP_COL_HI: begin
                n_byte = CMD_COL_HI_BASE | {5'd0, slot.column[6:4]};
                n_cmd  = 1'b1;
            end
            STEP_BLANK: begin
                n_byte = BLANK_COLUMN;
                n_last = 1'b1;
            end
            default: begin
                n_byte  = glyph_byte(slot.glyph, k);
                n_start = step == STEP_GLYPH0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (emit_now) begin
            r_byte  <= n_byte;
            r_cmd   <= n_cmd;
            r_start <= n_start;
            r_last  <= n_last;
        end
        if (o_pop) begin
            r_slot <= i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= STEP_PAGE;
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= emit_now;
            if (emit_now) begin
                r_busy <= step != STEP_BLANK;
                r_step <= step + 4'd1;
            end
        end
    end

    assign o_byte.valid           = r_valid;
    assign o_byte.byte_value      = r_byte;
    assign o_byte.is_command      = r_cmd;
    assign o_byte.starts_transfer = r_start;
    assign o_byte.last            = r_last;

endmodule

[src/oled_text_glyph_streamer_top.sv]
// Top level of the OLED text glyph streamer: front end, queue and byte serializer.
//
//   Channel   Direction  Word                                  Handshake
//   i_char    in         char_code, begins_text, start_column, valid/ready
//                        start_page
//   o_byte    out        byte_value, is_command,               valid/ready
//                        starts_transfer, last
//
// Each drawn character yields nine byte words, one per cycle from the output
// register while the sink is ready; the byte serializer in the back end sets
// that rate. A character is accepted whenever the two-entry queue has room,
// even while bytes of earlier characters are still going out or wait on a
// stalled sink. Characters dropped because the display is full are still
// accepted and yield nothing. Reset is synchronous and active low; it clears
// the cursor to column 0 of page 0 and empties the queue and the output
// register.
module oled_text_glyph_streamer_top
    import otgs_pkg::*;
#(
    parameter int DISPLAY_WIDTH = 128,
    parameter int PAGE_COUNT    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    otgs_char_if.sink   i_char,
    otgs_byte_if.source o_byte
);

    // Front end to queue.
    logic  push, full;
    t_slot push_slot;

    // Queue to back end.
    logic  pop, avail;
    t_slot pop_slot;

    // The front end applies the start position and line wrapping, and drops
    // characters once the cursor has run past the last page.
    otgs_front #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH),
        .PAGE_COUNT    (PAGE_COUNT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_full  (full),
        .o_push  (push),
        .o_slot  (push_slot)
    );

    // The queue holds cursor position and glyph code of pending characters.
    otgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_slot  (push_slot),
        .o_full  (full),
        .i_pop   (pop),
        .o_avail (avail),
        .o_slot  (pop_slot)
    );

    // The back end emits page, column and glyph bytes back to back while the
    // sink is ready, taking the next queued character right after the blank spacing column.
    otgs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_slot  (pop_slot),
        .o_pop   (pop),
        .o_byte  (o_byte)
    );

endmodule
